// ===== hdl/svpsb_pkg.sv =====
// Shared types and constants of the servo pulse schedule builder.
// Used by the width unit, the schedule cells and the top level.
package svpsb_pkg;

  localparam int SIDX_W  = 3;
  localparam int POS_W   = 8;
  localparam int PULSE_W = 16;
  localparam int ENTRY_W = 4;
  localparam int MASK_W  = 8;
  localparam int IDX_W   = 4;
  localparam int PROD_W  = POS_W + PULSE_W;
  localparam int EST_W   = PROD_W + 1;

  typedef struct packed {
    logic [PULSE_W-1:0] width;
    logic [IDX_W-1:0]   idx;
  } visitor_t;

  typedef struct packed {
    logic load;
    logic step;
  } cell_ctrl_t;

  typedef struct packed {
    logic [PULSE_W-1:0] width;
    logic [IDX_W-1:0]   rank;
    logic               cand;
  } cell_stat_t;

endpackage

// ===== hdl/svpsb_width.sv =====
// Width unit, four register stages, uses svpsb_pkg: min+position*(max-min)/255
// (0 at position 0, min if max<min). /255: reciprocal estimate, one correction.
module svpsb_width import svpsb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [POS_W-1:0]   position_i,
  input  logic [PULSE_W-1:0] min_pulse_i,
  input  logic [PULSE_W-1:0] max_pulse_i,
  output logic               done_o,
  output logic [PULSE_W-1:0] width_o
);

  logic [3:0]         vld_q;
  logic [PROD_W-1:0]  prod_q;
  logic [PULSE_W-1:0] lo_q;
  logic               zero_q;
  logic               inv_q;
  logic [EST_W-1:0]   est_q;
  logic [PULSE_W-1:0] quo_q;
  logic [PULSE_W-1:0] width_q;
  logic [PULSE_W-1:0] diff;
  logic [EST_W-1:0]   est_sum;
  logic [EST_W-1:0]   est_mul;
  logic [EST_W-1:0]   rem;
  logic [EST_W-1:0]   quo;

  always_comb begin
    diff    = max_pulse_i - min_pulse_i;
    est_sum = EST_W'(prod_q) + EST_W'(prod_q >> 8) + EST_W'(prod_q >> 16);
    est_mul = (est_q << 8) - est_q;
    rem     = EST_W'(prod_q) - est_mul;
    quo     = (rem >= EST_W'(255)) ? est_q + EST_W'(1) : est_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[2:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q <= PROD_W'(position_i) * PROD_W'(diff);
      lo_q   <= min_pulse_i;
      zero_q <= (position_i == '0);
      inv_q  <= (max_pulse_i < min_pulse_i);
    end
    if (vld_q[0]) begin
      est_q <= est_sum >> 8;
    end
    if (vld_q[1]) begin
      quo_q <= quo[PULSE_W-1:0];
    end
    if (vld_q[2]) begin
      if (zero_q) begin
        width_q <= '0;
      end else if (inv_q) begin
        width_q <= lo_q;
      end else begin
        width_q <= lo_q + quo_q;
      end
    end
  end

  assign done_o  = vld_q[3];
  assign width_o = width_q;

endmodule

// ===== hdl/svpsb_cell.sv =====
// One schedule cell: holds one servo's pulse width and ranks it against the
// widths that circulate through the ring of cells. Uses svpsb_pkg.
module svpsb_cell import svpsb_pkg::*; #(
  parameter int CELL_ID = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               wr_en_i,
  input  logic [PULSE_W-1:0] wr_width_i,
  input  cell_ctrl_t         ctrl_i,
  input  visitor_t           vis_i,
  output visitor_t           vis_o,
  output cell_stat_t         stat_o
);

  logic [PULSE_W-1:0] width_q;
  visitor_t           vis_q;
  logic [IDX_W-1:0]   rank_q;
  logic               dup_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= '0;
      vis_q   <= '0;
      rank_q  <= '0;
      dup_q   <= 1'b0;
    end else begin
      if (wr_en_i) begin
        width_q <= wr_width_i;
      end
      if (ctrl_i.load) begin
        vis_q.width <= width_q;
        vis_q.idx   <= IDX_W'(CELL_ID);
        rank_q      <= '0;
        dup_q       <= 1'b0;
      end else if (ctrl_i.step) begin
        vis_q <= vis_i;
        if (vis_q.width < width_q) begin
          rank_q <= rank_q + IDX_W'(1);
        end
        if (vis_q.width == width_q && vis_q.idx < IDX_W'(CELL_ID)) begin
          dup_q <= 1'b1;
        end
      end
    end
  end

  assign vis_o        = vis_q;
  assign stat_o.width = width_q;
  assign stat_o.rank  = rank_q;
  assign stat_o.cand  = (width_q != '0) && !dup_q;

endmodule

// ===== hdl/servo_pulse_schedule_builder_unit.sv =====
// Servo pulse schedule builder, top level.
// Depends on svpsb_pkg, svpsb_width and svpsb_cell.
//
// Input channel (in_valid_i / in_stall_o): one update carries a servo index,
// a position and the minimum and maximum pulse widths. The new width is
// stored in that servo's cell; an index at or above SERVO_COUNT stores
// nothing but still produces a schedule.
// Output channel (out_valid_o / out_stall_i): one transfer per schedule
// entry. Entry 0 is time 0; then one entry per distinct nonzero width in
// ascending order, each with the mask of outputs still high. last_o marks
// the final entry.
// Sequence: the width unit computes the width, which is written into the cell;
// a load state and SERVO_COUNT ring steps follow. Entry 0 comes next, then the
// rank positions are swept in turn up to the highest distinct width, with one
// entry for each position that holds a candidate.
// The input is stalled from the accepting edge until the final entry is in
// the output register; that entry may wait there while the next update is
// taken. An output stall holds the register and freezes the sequencer in the
// states that emit entries. Reset clears every stored width to zero and empties the output register.
module servo_pulse_schedule_builder_unit import svpsb_pkg::*; #(
  parameter int SERVO_COUNT = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [SIDX_W-1:0]  servo_index_i,
  input  logic [POS_W-1:0]   position_i,
  input  logic [PULSE_W-1:0] min_pulse_i,
  input  logic [PULSE_W-1:0] max_pulse_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [ENTRY_W-1:0] entry_index_o,
  output logic [PULSE_W-1:0] edge_time_o,
  output logic [MASK_W-1:0]  high_mask_o,
  output logic               last_o
);

  localparam int StepW = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;
  localparam int CntW  = $clog2(SERVO_COUNT + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_LOAD,
    ST_RING,
    ST_ZERO,
    ST_EMIT
  } state_e;

  state_e             state_q;
  logic [SIDX_W-1:0]  idx_q;
  logic [StepW-1:0]   step_q;
  logic [StepW-1:0]   pos_q;
  logic [CntW-1:0]    remain_q;
  logic [ENTRY_W-1:0] entry_q;
  logic               out_valid_q;
  logic [ENTRY_W-1:0] entry_index_q;
  logic [PULSE_W-1:0] edge_time_q;
  logic [MASK_W-1:0]  high_mask_q;
  logic               last_q;

  logic               in_xfer;
  logic               calc_done;
  logic [PULSE_W-1:0] calc_width;
  cell_ctrl_t         ctrl;
  logic [SERVO_COUNT-1:0] wr_en;
  visitor_t           vis [SERVO_COUNT];
  cell_stat_t         stat [SERVO_COUNT];
  logic [SERVO_COUNT-1:0] hit;
  logic [SERVO_COUNT-1:0] above;
  logic [PULSE_W-1:0] sel_width;
  logic [PULSE_W-1:0] cmp_time;
  logic [CntW-1:0]    cand_cnt;
  logic               out_free;
  logic               out_load;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = out_free && ((state_q == ST_ZERO) || (state_q == ST_EMIT && hit != '0));

  svpsb_width u_width (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_xfer),
    .position_i  (position_i),
    .min_pulse_i (min_pulse_i),
    .max_pulse_i (max_pulse_i),
    .done_o      (calc_done),
    .width_o     (calc_width)
  );

  always_comb begin
    ctrl.load = (state_q == ST_LOAD);
    ctrl.step = (state_q == ST_RING);
  end

  for (genvar j = 0; j < SERVO_COUNT; j++) begin : g_cell
    localparam int Prev = (j == 0) ? SERVO_COUNT - 1 : j - 1;

    assign wr_en[j] = (state_q == ST_CALC) && calc_done && (5'(idx_q) == 5'(j));

    svpsb_cell #(
      .CELL_ID (j)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .wr_en_i    (wr_en[j]),
      .wr_width_i (calc_width),
      .ctrl_i     (ctrl),
      .vis_i      (vis[Prev]),
      .vis_o      (vis[j]),
      .stat_o     (stat[j])
    );
  end

  always_comb begin
    sel_width = '0;
    cand_cnt  = '0;
    for (int j = 0; j < SERVO_COUNT; j++) begin
      hit[j]   = stat[j].cand && (stat[j].rank == IDX_W'(pos_q));
      cand_cnt = cand_cnt + CntW'(stat[j].cand);
      if (hit[j]) begin
        sel_width = sel_width | stat[j].width;
      end
    end
    cmp_time = (state_q == ST_ZERO) ? '0 : sel_width;
    for (int j = 0; j < SERVO_COUNT; j++) begin
      above[j] = (stat[j].width > cmp_time);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      idx_q         <= '0;
      step_q        <= '0;
      pos_q         <= '0;
      remain_q      <= '0;
      entry_q       <= '0;
      out_valid_q   <= 1'b0;
      entry_index_q <= '0;
      edge_time_q   <= '0;
      high_mask_q   <= '0;
      last_q        <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            idx_q   <= servo_index_i;
            state_q <= ST_CALC;
          end
        end
        ST_CALC: begin
          if (calc_done) begin
            state_q <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          step_q  <= '0;
          state_q <= ST_RING;
        end
        ST_RING: begin
          step_q <= step_q + StepW'(1);
          if (step_q == StepW'(SERVO_COUNT - 1)) begin
            state_q <= ST_ZERO;
          end
        end
        ST_ZERO: begin
          if (out_free) begin
            entry_index_q <= '0;
            edge_time_q   <= '0;
            high_mask_q   <= MASK_W'(above);
            last_q        <= (cand_cnt == '0);
            remain_q      <= cand_cnt;
            entry_q       <= ENTRY_W'(1);
            pos_q         <= '0;
            state_q       <= (cand_cnt == '0) ? ST_IDLE : ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            pos_q <= pos_q + StepW'(1);
            if (hit != '0) begin
              entry_index_q <= entry_q;
              edge_time_q   <= sel_width;
              high_mask_q   <= MASK_W'(above);
              last_q        <= (remain_q == CntW'(1));
              remain_q      <= remain_q - CntW'(1);
              entry_q       <= entry_q + ENTRY_W'(1);
              if (remain_q == CntW'(1)) begin
                state_q <= ST_IDLE;
              end
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign entry_index_o = entry_index_q;
  assign edge_time_o   = edge_time_q;
  assign high_mask_o   = high_mask_q;
  assign last_o        = last_q;

endmodule

// ===== hdl/svpsb_checker.sv =====
// Port-level checks of the servo pulse schedule builder, bound to the top.
// Depends on svpsb_pkg and servo_pulse_schedule_builder_unit.
module svpsb_checker import svpsb_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [ENTRY_W-1:0] entry_index_o,
  input logic [PULSE_W-1:0] edge_time_o,
  input logic [MASK_W-1:0]  high_mask_o,
  input logic               last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(edge_time_o)
      && $stable(high_mask_o) && $stable(entry_index_o) && $stable(last_o))
    else $error("stalled output transfer changed");

  a_busy_after_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again before the schedule was built");

  a_overflow_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && entry_index_o == '0 |-> edge_time_o == '0)
    else $error("overflow entry with nonzero time");

  a_edge_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && entry_index_o != '0 |-> edge_time_o != '0)
    else $error("edge entry at time zero");

  a_last_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> high_mask_o == '0)
    else $error("final entry leaves an output high");

endmodule

bind servo_pulse_schedule_builder_unit svpsb_checker u_svpsb_checker (.*);
